/* rtl/itp_pkg.sv */
`timescale 1ns / 1ps
// Package for the IPv6 text parser: record type passed from the front end
// to the back end, plus shared sizes. No dependencies.
package itp_pkg;

    localparam int GROUPS      = 8;
    localparam int GROUP_W     = 16;
    localparam int MAX_DIGITS  = 4;
    localparam int Q_DEPTH     = 2;

    localparam logic [7:0] CHAR_COLON = 8'h3a;

    typedef logic [GROUP_W-1:0] group_t;

    // one finished address text, ready for gap expansion
    typedef struct packed {
        group_t [GROUPS-1:0] groups;
        logic [3:0]          count;
        logic [3:0]          gap_pos;
        logic                gap_seen;
        logic                malformed;
    } itp_rec_t;

    typedef struct packed {
        logic     valid;
        itp_rec_t rec;
    } itp_push_t;

endpackage

/* rtl/ipv6_text_parser_core.sv */
`timescale 1ns / 1ps
// IPv6 text parser top level: front end, record queue, back end. Uses itp_pkg.
// Throughput: one character per cycle while the record queue is not full.
// A record enters the queue when its last character is taken, then loads into the output register once that is free.
// A two-entry queue lets the front keep taking characters while a result waits.
// Synchronous active-low reset clears all control state; no clearing pass.
module ipv6_text_parser_core (
    input  logic         aclk,
    input  logic         aresetn,
    input  logic         s_tvalid,
    output logic         s_tready,
    input  logic [7:0]   s_tdata,   // [7:0] char_code
    input  logic         s_tlast,
    output logic         m_tvalid,
    input  logic         m_tready,
    output logic [127:0] m_tdata,   // [63:0] addr_high, [127:64] addr_low
    output logic [0:0]   m_tuser    // [0] malformed
);

    itp_pkg::itp_push_t push;
    itp_pkg::itp_rec_t  head;
    logic push_ready;
    logic head_valid;
    logic pop;

    assign s_tready = push_ready;

    itp_front u_front (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .in_valid  (s_tvalid),
        .in_ready  (push_ready),
        .char_code (s_tdata),
        .last_char (s_tlast),
        .push      (push)
    );

    itp_queue u_queue (
        .aclk       (aclk),
        .aresetn    (aresetn),
        .push       (push),
        .push_ready (push_ready),
        .head_valid (head_valid),
        .head       (head),
        .pop        (pop)
    );

    itp_back u_back (
        .aclk       (aclk),
        .aresetn    (aresetn),
        .head_valid (head_valid),
        .head       (head),
        .pop        (pop),
        .m_tvalid   (m_tvalid),
        .m_tready   (m_tready),
        .m_tdata    (m_tdata),
        .m_tuser    (m_tuser)
    );

    a_bad_is_zero: assert property (@(posedge aclk) disable iff (!aresetn)
        (m_tvalid && m_tuser[0]) |-> (m_tdata == '0))
        else $error("malformed result carries a nonzero address");

    a_push_fits: assert property (@(posedge aclk) disable iff (!aresetn)
        push.valid |-> push_ready)
        else $error("record pushed into a full queue");

    a_pop_loads: assert property (@(posedge aclk) disable iff (!aresetn)
        pop |=> m_tvalid)
        else $error("popped record did not reach the output register");

    a_pop_has_data: assert property (@(posedge aclk) disable iff (!aresetn)
        pop |-> head_valid)
        else $error("pop from an empty queue");

endmodule

/* rtl/itp_front.sv */
`timescale 1ns / 1ps
// Front end: takes one character per item, builds groups and tracks the
// gap and error state. Emits a record on the last character. Uses itp_pkg.
module itp_front (
    input  logic            aclk,
    input  logic            aresetn,
    input  logic            in_valid,
    input  logic            in_ready,
    input  logic [7:0]      char_code,
    input  logic            last_char,
    output itp_pkg::itp_push_t push
);

    logic [15:0] acc_reg, acc_next;
    logic [2:0]  dc_reg, dc_next;
    logic [3:0]  cnt_reg, cnt_next;
    logic [3:0]  gp_reg, gp_next;
    logic        gs_reg, gs_next;
    logic        pc_reg, pc_next;
    logic        err_reg, err_next;
    itp_pkg::group_t [itp_pkg::GROUPS-1:0] store_reg;

    logic        hex_ok;
    logic [3:0]  hex_val;
    logic        made_gap;
    logic        do_close;
    logic        wr_en;
    logic [15:0] close_val;
    logic        accept;
    itp_pkg::group_t [itp_pkg::GROUPS-1:0] store_fin;

    assign accept = in_valid && in_ready;

    always_comb begin
        hex_ok  = 1'b1;
        hex_val = 4'd0;
        if (char_code >= 8'h30 && char_code <= 8'h39) begin
            hex_val = 4'(char_code - 8'h30);
        end else if (char_code >= 8'h61 && char_code <= 8'h66) begin
            hex_val = 4'(char_code - 8'h57);
        end else if (char_code >= 8'h41 && char_code <= 8'h46) begin
            hex_val = 4'(char_code - 8'h37);
        end else begin
            hex_ok = 1'b0;
        end
    end

    always_comb begin
        acc_next  = acc_reg;
        dc_next   = dc_reg;
        cnt_next  = cnt_reg;
        gp_next   = gp_reg;
        gs_next   = gs_reg;
        pc_next   = pc_reg;
        err_next  = err_reg;
        made_gap  = 1'b0;
        do_close  = 1'b0;
        wr_en     = 1'b0;
        close_val = acc_reg;

        if (hex_ok) begin
            if (pc_reg && cnt_reg == 4'd0 && !gs_reg) begin
                err_next = 1'b1;
            end
            if (dc_reg >= 3'(itp_pkg::MAX_DIGITS)) begin
                err_next = 1'b1;
            end else begin
                acc_next = {acc_reg[11:0], hex_val};
                dc_next  = dc_reg + 3'd1;
            end
            pc_next = 1'b0;
        end else if (char_code == itp_pkg::CHAR_COLON) begin
            if (dc_reg != 3'd0) begin
                do_close = 1'b1;
            end else if (pc_reg) begin
                if (gs_reg) begin
                    err_next = 1'b1;
                end else begin
                    gs_next  = 1'b1;
                    gp_next  = cnt_reg;
                    made_gap = 1'b1;
                end
            end
            pc_next = 1'b1;
        end else begin
            err_next = 1'b1;
            pc_next  = 1'b0;
        end

        if (last_char && dc_next != 3'd0) begin
            do_close  = 1'b1;
            close_val = acc_next;
        end

        if (do_close) begin
            if (cnt_reg >= 4'(itp_pkg::GROUPS)) begin
                err_next = 1'b1;
            end else begin
                wr_en    = 1'b1;
                cnt_next = cnt_reg + 4'd1;
            end
            acc_next = 16'd0;
            dc_next  = 3'd0;
        end

        if (last_char) begin
            if (pc_next && !made_gap) begin
                err_next = 1'b1;
            end
            if (gs_next ? (cnt_next >= 4'(itp_pkg::GROUPS))
                        : (cnt_next != 4'(itp_pkg::GROUPS))) begin
                err_next = 1'b1;
            end
        end

        store_fin = store_reg;
        if (wr_en) begin
            store_fin[cnt_reg[2:0]] = close_val;
        end
    end

    always_comb begin
        push.valid         = accept && last_char;
        push.rec.groups    = store_fin;
        push.rec.count     = cnt_next;
        push.rec.gap_pos   = gp_next;
        push.rec.gap_seen  = gs_next;
        push.rec.malformed = err_next;
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            acc_reg <= 16'd0;
            dc_reg  <= 3'd0;
            cnt_reg <= 4'd0;
            gp_reg  <= 4'd0;
            gs_reg  <= 1'b0;
            pc_reg  <= 1'b0;
            err_reg <= 1'b0;
        end else if (accept) begin
            if (last_char) begin
                acc_reg <= 16'd0;
                dc_reg  <= 3'd0;
                cnt_reg <= 4'd0;
                gp_reg  <= 4'd0;
                gs_reg  <= 1'b0;
                pc_reg  <= 1'b0;
                err_reg <= 1'b0;
            end else begin
                acc_reg <= acc_next;
                dc_reg  <= dc_next;
                cnt_reg <= cnt_next;
                gp_reg  <= gp_next;
                gs_reg  <= gs_next;
                pc_reg  <= pc_next;
                err_reg <= err_next;
            end
        end
    end

    // unused entries are never read, so the store needs no reset
    always_ff @(posedge aclk) begin
        if (accept && wr_en) begin
            store_reg[cnt_reg[2:0]] <= close_val;
        end
    end

endmodule

/* rtl/itp_queue.sv */
`timescale 1ns / 1ps
// Two-entry record queue between front and back end.
// Uses itp_pkg.
module itp_queue (
    input  logic               aclk,
    input  logic               aresetn,
    input  itp_pkg::itp_push_t push,
    output logic               push_ready,
    output logic               head_valid,
    output itp_pkg::itp_rec_t  head,
    input  logic               pop
);

    itp_pkg::itp_rec_t mem [itp_pkg::Q_DEPTH];
    logic       wr_ptr_reg;
    logic       rd_ptr_reg;
    logic [1:0] cnt_reg;
    logic       do_push;
    logic       do_pop;

    assign push_ready = cnt_reg != 2'(itp_pkg::Q_DEPTH);
    assign head_valid = cnt_reg != 2'd0;
    assign head       = mem[rd_ptr_reg];
    assign do_push    = push.valid && push_ready;
    assign do_pop     = pop && head_valid;

    always_ff @(posedge aclk) begin
        if (do_push) begin
            mem[wr_ptr_reg] <= push.rec;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            wr_ptr_reg <= 1'b0;
            rd_ptr_reg <= 1'b0;
            cnt_reg    <= 2'd0;
        end else begin
            if (do_push) begin
                wr_ptr_reg <= ~wr_ptr_reg;
            end
            if (do_pop) begin
                rd_ptr_reg <= ~rd_ptr_reg;
            end
            case ({do_push, do_pop})
                2'b10:   cnt_reg <= cnt_reg + 2'd1;
                2'b01:   cnt_reg <= cnt_reg - 2'd1;
                default: cnt_reg <= cnt_reg;
            endcase
        end
    end

endmodule

/* rtl/itp_back.sv */
`timescale 1ns / 1ps
// Back end: expands the "::" gap of a record into the 128-bit address and
// holds it in the output register. Uses itp_pkg.
module itp_back (
    input  logic              aclk,
    input  logic              aresetn,
    input  logic              head_valid,
    input  itp_pkg::itp_rec_t head,
    output logic              pop,
    output logic              m_tvalid,
    input  logic              m_tready,
    output logic [127:0]      m_tdata,
    output logic [0:0]        m_tuser
);

    logic         valid_reg;
    logic [127:0] data_reg;
    logic         bad_reg;
    logic [3:0]   gp;
    itp_pkg::group_t [itp_pkg::GROUPS-1:0] full;
    logic [4:0]   jc;
    logic [2:0]   src;

    assign pop = head_valid && (!valid_reg || m_tready);

    always_comb begin
        gp = head.gap_seen ? head.gap_pos : head.count;
        if (gp > head.count) begin
            gp = head.count;
        end
        for (int j = 0; j < itp_pkg::GROUPS; j++) begin
            jc  = 5'(j) + 5'(head.count);
            src = jc[2:0];
            if (head.malformed) begin
                full[j] = '0;
            end else if (4'(j) < gp) begin
                full[j] = head.groups[j];
            end else if (jc >= 5'(itp_pkg::GROUPS) + 5'(gp)) begin
                full[j] = head.groups[src];
            end else begin
                full[j] = '0;
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            valid_reg <= 1'b0;
        end else if (pop) begin
            valid_reg <= 1'b1;
        end else if (m_tready) begin
            valid_reg <= 1'b0;
        end
    end

    always_ff @(posedge aclk) begin
        if (pop) begin
            data_reg <= {full[4], full[5], full[6], full[7],
                         full[0], full[1], full[2], full[3]};
            bad_reg  <= head.malformed;
        end
    end

    assign m_tvalid   = valid_reg;
    assign m_tdata    = data_reg;
    assign m_tuser[0] = bad_reg;

endmodule
